// ===== rtl/core/gwms_pkg.sv =====
package gwms_pkg;

  // default query store depth
  localparam int QUERY_MAX_DEFAULT = 64;

  localparam logic [6:0] QUERY_LENGTH_RESET = 7'd64;

  // action codes
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_PUSH    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // wildcard base symbols
  localparam logic [7:0] CH_N_UPPER = 8'h4E;
  localparam logic [7:0] CH_N_LOWER = 8'h6E;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] symbol;
    logic [5:0] query_index;
  } item_t;

  typedef struct packed {
    logic [6:0]  match_score;
    logic [31:0] window_start;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic push_full;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/gwms_ram.sv =====
module gwms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/gwms_ctrl.sv =====
module gwms_ctrl import gwms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.accept = item_valid;
        if (item_valid && status.push_full) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_last_to_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && status.scan_last) |=> (state == S_FINISH))
    else $error("scan did not end after last step");

  a_emit_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (state == S_IDLE))
    else $error("controller not idle after emit");

  a_full_push_scans: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && status.push_full) |=> (state == S_SCAN))
    else $error("window push did not start a scan");
`endif

endmodule

// ===== rtl/core/gwms_dp.sv =====
module gwms_dp import gwms_pkg::*; #(
  parameter int QUERY_MAX = QUERY_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  logic       cfg_write,
  input  logic [6:0] cfg_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result
);

  localparam int AW    = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
  localparam int CNT_W = $clog2(QUERY_MAX + 1);
  localparam int SW    = CNT_W + 1;

  logic [6:0]       query_length;
  logic [CNT_W-1:0] len;
  logic [31:0]      ql_ext;

  logic [AW-1:0]    wptr;
  logic [AW-1:0]    wptr_inc;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_inc;
  logic [31:0]      base_pos;
  logic [AW-1:0]    baddr;
  logic [AW-1:0]    k;
  logic [AW-1:0]    len_m1;
  logic [AW-1:0]    start;
  logic             cmp_en;
  logic [6:0]       score;
  logic [31:0]      win_start;
  logic [SW-1:0]    wptr_ext;
  logic [SW-1:0]    len_ext;

  logic             q_we;
  logic             b_we;
  logic [7:0]       q_rdata;
  logic [7:0]       b_rdata;
  logic             hit;

  // clamp the window length into 1 .. QUERY_MAX
  always_comb begin
    ql_ext = 32'(query_length);
    if (ql_ext == 32'd0) begin
      len = CNT_W'(1);
    end else if (ql_ext > 32'(QUERY_MAX)) begin
      len = CNT_W'(QUERY_MAX);
    end else begin
      len = CNT_W'(ql_ext);
    end
  end

  assign wptr_inc = (wptr == AW'(QUERY_MAX - 1)) ? '0 : wptr + AW'(1);
  assign fill_inc = (fill == CNT_W'(QUERY_MAX)) ? fill : fill + CNT_W'(1);
  assign len_m1   = AW'(len - CNT_W'(1));

  // oldest window entry once the push is done
  assign wptr_ext = SW'(wptr_inc);
  assign len_ext  = SW'(len);
  assign start    = (wptr_ext >= len_ext) ? AW'(wptr_ext - len_ext)
                                          : AW'(wptr_ext + SW'(QUERY_MAX) - len_ext);

  assign q_we = cmd.accept && (item.action == ACT_LOAD) &&
                (32'(item.query_index) < 32'(QUERY_MAX));
  assign b_we = cmd.accept && (item.action == ACT_PUSH);

  gwms_ram #(.WIDTH(8), .DEPTH(QUERY_MAX)) u_query_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (AW'(item.query_index)),
    .wdata (item.symbol),
    .raddr (k),
    .rdata (q_rdata)
  );

  gwms_ram #(.WIDTH(8), .DEPTH(QUERY_MAX)) u_base_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (wptr),
    .wdata (item.symbol),
    .raddr (baddr),
    .rdata (b_rdata)
  );

  assign hit = (b_rdata == q_rdata) || (b_rdata == CH_N_UPPER) || (b_rdata == CH_N_LOWER);

  assign status.push_full = (item.action == ACT_PUSH) && (fill_inc >= len);
  assign status.scan_last = (k == len_m1);
  assign status.out_free  = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_length <= QUERY_LENGTH_RESET;
      wptr         <= '0;
      fill         <= '0;
      base_pos     <= '0;
      cmp_en       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        query_length <= cfg_data;
      end
      if (cmd.accept) begin
        case (item.action)
          ACT_PUSH: begin
            wptr     <= wptr_inc;
            fill     <= fill_inc;
            base_pos <= base_pos + 32'd1;
          end
          ACT_RESTART: begin
            fill     <= '0;
            base_pos <= '0;
          end
          default: begin
          end
        endcase
      end
      cmp_en <= cmd.step;
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // scan pointers, score and output payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      baddr     <= start;
      k         <= '0;
      score     <= '0;
      win_start <= base_pos + 32'd1 - 32'(len);
    end else begin
      if (cmd.step) begin
        baddr <= (baddr == AW'(QUERY_MAX - 1)) ? '0 : baddr + AW'(1);
        k     <= k + AW'(1);
      end
      if (cmp_en && hit) begin
        score <= score + 7'd1;
      end
    end
    if (cmd.emit) begin
      result.match_score  <= score;
      result.window_start <= win_start;
    end
  end

`ifndef SYNTHESIS
  a_step_compares: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> cmp_en)
    else $error("read issued without a compare");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> result_valid)
    else $error("emitted result not valid");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(QUERY_MAX))
    else $error("window fill above depth");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !cmd.emit) |=> !result_valid)
    else $error("taken result not cleared");
`endif

endmodule

// ===== rtl/core/gapless_wildcard_match_scorer_unit.sv =====
// gapless wildcard match scorer
//
// item channel (item_valid / item_stall / item) carries one transaction per
// action: load a query symbol at query_index, push a base symbol, or restart
// the base sequence. result channel (result_valid / result_stall / result)
// gives match_score and window_start for each push that completes a window.
// cfg_write / cfg_data set query_length; write only while the block is idle.
//
// loads, restarts and pushes that do not complete a window leave the block idle.
// a push that completes a window starts a scan with one compare per cycle,
// since the query and window memories each give one symbol per cycle to a
// single shared compare and counter; the scan then goes to finish and emit.
// the result sits in an output register; while the receiver stalls it holds
// there and the block keeps taking transactions until the next scored window
// needs that register.
// reset clears the window fill, position and output valid and sets
// query_length to 64; the query store is undefined until loaded.
module gapless_wildcard_match_scorer_unit import gwms_pkg::*; #(
  parameter int QUERY_MAX = QUERY_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  input  logic       cfg_write,
  input  logic [6:0] cfg_data
);

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: idle / scan / finish / emit
  gwms_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // query and window memories, counters, shared compare and output register
  gwms_dp #(.QUERY_MAX(QUERY_MAX)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
